@@ rtl/bnm_pkg.sv @@
// ----------------------------------------------------------------------------
// bnm_pkg
// Shared types and constants for the breath/note MIDI event generator.
// ----------------------------------------------------------------------------
`default_nettype none

package bnm_pkg;

	localparam int unsigned NOTE_W  = 7;
	localparam int unsigned DATA_W  = 7;
	localparam int unsigned TICK_W  = 16;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CIDX_W  = 2;

	localparam int unsigned QDEPTH  = 4;
	localparam int unsigned QPTR_W  = 2;
	localparam int unsigned QCNT_W  = 3;

	typedef enum logic [1:0] {
		EV_CC  = 2'd0,
		EV_ON  = 2'd1,
		EV_OFF = 2'd2
	} kind_t;

	localparam logic [CIDX_W-1:0] CFG_BREATH_THR = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_CC_THR     = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_CC_NUM     = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_SETTLE     = 2'd3;

	localparam logic [DATA_W-1:0] RST_BREATH_THR = 7'd10;
	localparam logic [DATA_W-1:0] RST_CC_THR     = 7'd1;
	localparam logic [DATA_W-1:0] RST_CC_NUM     = 7'd2;
	localparam logic [TICK_W-1:0] RST_SETTLE     = 16'd25;

	typedef struct packed {
		logic [DATA_W-1:0] breath_thr;
		logic [DATA_W-1:0] cc_thr;
		logic [DATA_W-1:0] cc_num;
		logic [TICK_W-1:0] settle;
	} cfg_t;

	typedef struct packed {
		kind_t             kind;
		logic [DATA_W-1:0] first;
		logic [DATA_W-1:0] second;
		logic              last;
	} event_t;

endpackage

`default_nettype wire

@@ rtl/bnm_core.sv @@
// ----------------------------------------------------------------------------
// bnm_core
// Note/breath state and event decode for one tick; up to two events per item.
// ----------------------------------------------------------------------------
`default_nettype none

module bnm_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fire,
	input  wire logic [bnm_pkg::NOTE_W-1:0]    key,
	input  wire logic [bnm_pkg::DATA_W-1:0]    breath,
	input  wire logic [bnm_pkg::DATA_W-1:0]    vel,
	input  wire bnm_pkg::cfg_t                 cfg,
	output bnm_pkg::event_t                    ev0,
	output bnm_pkg::event_t                    ev1,
	output logic [1:0]                         ev_cnt
);

	logic                          sounding_q, sounding_d;
	logic                          settling_q, settling_d;
	logic [bnm_pkg::NOTE_W-1:0]    held_q, held_d;
	logic [bnm_pkg::NOTE_W-1:0]    cand_q, cand_d;
	logic [bnm_pkg::DATA_W-1:0]    last_cc_q, last_cc_d;
	logic [bnm_pkg::DATA_W-1:0]    cap_vel_q, cap_vel_d;
	logic [bnm_pkg::TICK_W-1:0]    stable_q, stable_d;

	logic [bnm_pkg::DATA_W-1:0]    diff;
	logic [bnm_pkg::TICK_W-1:0]    stable_inc;
	logic                          cc_hit;
	logic                          note_hit;
	bnm_pkg::event_t               cc_ev;
	bnm_pkg::event_t               note_ev;

	always_comb begin
		sounding_d = sounding_q;
		settling_d = settling_q;
		held_d     = held_q;
		cand_d     = cand_q;
		last_cc_d  = last_cc_q;
		cap_vel_d  = cap_vel_q;
		stable_d   = stable_q;
		cc_hit     = 1'b0;
		note_hit   = 1'b0;
		ev0        = '0;
		ev1        = '0;
		ev_cnt     = 2'd0;

		diff       = (breath >= last_cc_q) ? (breath - last_cc_q) : (last_cc_q - breath);
		stable_inc = (stable_q == '1) ? stable_q : (stable_q + 1'b1);

		cc_ev.kind   = bnm_pkg::EV_CC;
		cc_ev.first  = cfg.cc_num;
		cc_ev.second = breath;
		cc_ev.last   = 1'b0;
		note_ev      = '0;

		if (settling_q) begin
			if (key != cand_q) begin
				cand_d   = key;
				stable_d = '0;
			end else begin
				stable_d = stable_inc;
				if (stable_inc >= cfg.settle) begin
					ev0.kind   = bnm_pkg::EV_ON;
					ev0.first  = cand_q;
					ev0.second = cap_vel_q;
					ev1.kind   = bnm_pkg::EV_OFF;
					ev1.first  = held_q;
					ev1.second = cap_vel_q;
					ev1.last   = 1'b1;
					ev_cnt     = 2'd2;
					held_d     = cand_q;
					settling_d = 1'b0;
					sounding_d = 1'b1;
				end
			end
		end else begin
			if (diff > cfg.cc_thr) begin
				cc_hit    = 1'b1;
				last_cc_d = breath;
			end
			if (breath < cfg.breath_thr) begin
				if (sounding_q) begin
					note_hit       = 1'b1;
					note_ev.kind   = bnm_pkg::EV_OFF;
					note_ev.first  = held_q;
					note_ev.second = breath;
					sounding_d     = 1'b0;
				end
			end else if (key != '0) begin
				if (!sounding_q) begin
					note_hit       = 1'b1;
					note_ev.kind   = bnm_pkg::EV_ON;
					note_ev.first  = key;
					note_ev.second = vel;
					held_d         = key;
					sounding_d     = 1'b1;
				end else if (key != held_q) begin
					settling_d = 1'b1;
					cand_d     = key;
					stable_d   = '0;
					cap_vel_d  = vel;
				end
			end
			note_ev.last = 1'b1;
			if (cc_hit && note_hit) begin
				ev0    = cc_ev;
				ev1    = note_ev;
				ev_cnt = 2'd2;
			end else if (cc_hit) begin
				ev0      = cc_ev;
				ev0.last = 1'b1;
				ev_cnt   = 2'd1;
			end else if (note_hit) begin
				ev0    = note_ev;
				ev_cnt = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sounding_q <= 1'b0;
			settling_q <= 1'b0;
			held_q     <= '0;
			cand_q     <= '0;
			last_cc_q  <= '0;
			cap_vel_q  <= '0;
			stable_q   <= '0;
		end else if (fire) begin
			sounding_q <= sounding_d;
			settling_q <= settling_d;
			held_q     <= held_d;
			cand_q     <= cand_d;
			last_cc_q  <= last_cc_d;
			cap_vel_q  <= cap_vel_d;
			stable_q   <= stable_d;
		end
	end

	// settling only starts from a sounding note and ends with one sounding
	a_settle_sounding: assert property (@(posedge clk) disable iff (!arst_n)
		settling_q |-> sounding_q)
		else $error("settling without a sounding note");

	// a note switch always carries both events
	a_switch_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && settling_q && !settling_d) |-> (ev_cnt == 2'd2))
		else $error("legato switch without two events");

endmodule

`default_nettype wire

@@ rtl/bnm_evq.sv @@
// ----------------------------------------------------------------------------
// bnm_evq
// Small event queue: takes up to two events per cycle while it has room, delivers one per cycle when popped.
// ----------------------------------------------------------------------------
`default_nettype none

module bnm_evq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [1:0]                    push_n,
	input  wire bnm_pkg::event_t               ev0,
	input  wire bnm_pkg::event_t               ev1,
	input  wire logic                          pop,
	output bnm_pkg::event_t                    head,
	output logic                               not_empty,
	output logic                               room
);

	bnm_pkg::event_t                 mem [bnm_pkg::QDEPTH];
	logic [bnm_pkg::QPTR_W-1:0]      wr_q;
	logic [bnm_pkg::QPTR_W-1:0]      rd_q;
	logic [bnm_pkg::QCNT_W-1:0]      cnt_q;
	logic [bnm_pkg::QPTR_W-1:0]      wr_p1;
	logic                            pop_ok;

	assign wr_p1     = wr_q + 1'b1;
	assign not_empty = (cnt_q != '0);
	assign room      = (cnt_q <= bnm_pkg::QCNT_W'(bnm_pkg::QDEPTH - 2));
	assign head      = mem[rd_q];
	assign pop_ok    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wr_q] <= ev0;
		end
		if (push_n == 2'd2) begin
			mem[wr_p1] <= ev1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + bnm_pkg::QPTR_W'(push_n);
			rd_q  <= rd_q + bnm_pkg::QPTR_W'(pop_ok);
			cnt_q <= cnt_q + bnm_pkg::QCNT_W'(push_n) - bnm_pkg::QCNT_W'(pop_ok);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> room)
		else $error("event queue push without room");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= bnm_pkg::QCNT_W'(bnm_pkg::QDEPTH))
		else $error("event queue count out of range");

endmodule

`default_nettype wire

@@ rtl/breath_note_midi_event_generator.sv @@
// ----------------------------------------------------------------------------
// breath_note_midi_event_generator
// Turns key note / breath ticks into control change, note on and note off
// events, with legato settling.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  in        in_valid/in_stall   key_note, breath_level, velocity
//  out       out_valid/out_stall event_kind, data_first, data_second, final_of_run
//  cfg       cfg_we              cfg_index, cfg_data
//
//  An item is registered, then decoded from that register into zero to two
//  events, which land in a four-entry event queue. One item per cycle is taken
//  while the queue has room for two events; the output drains one event per
//  cycle while out_stall is low, so items causing two events back up the queue.
//  Reset clears note state, config to defaults and empties the queue.
//  out_stall backs up the queue and then raises in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module breath_note_midi_event_generator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [bnm_pkg::NOTE_W-1:0]    key_note,
	input  wire logic [bnm_pkg::DATA_W-1:0]    breath_level,
	input  wire logic [bnm_pkg::DATA_W-1:0]    velocity,

	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         event_kind,
	output logic [bnm_pkg::DATA_W-1:0]         data_first,
	output logic [bnm_pkg::DATA_W-1:0]         data_second,
	output logic                               final_of_run,

	input  wire logic                          cfg_we,
	input  wire logic [bnm_pkg::CIDX_W-1:0]    cfg_index,
	input  wire logic [bnm_pkg::CFG_W-1:0]     cfg_data
);

	bnm_pkg::cfg_t                 cfg_q;

	logic                          valid_s1;
	logic [bnm_pkg::NOTE_W-1:0]    key_s1;
	logic [bnm_pkg::DATA_W-1:0]    breath_s1;
	logic [bnm_pkg::DATA_W-1:0]    vel_s1;

	bnm_pkg::event_t               ev0;
	bnm_pkg::event_t               ev1;
	bnm_pkg::event_t               head;
	logic [1:0]                    ev_cnt;
	logic                          room;
	logic                          fire;
	logic                          take;

	assign fire     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.breath_thr <= bnm_pkg::RST_BREATH_THR;
			cfg_q.cc_thr     <= bnm_pkg::RST_CC_THR;
			cfg_q.cc_num     <= bnm_pkg::RST_CC_NUM;
			cfg_q.settle     <= bnm_pkg::RST_SETTLE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bnm_pkg::CFG_BREATH_THR: cfg_q.breath_thr <= cfg_data[bnm_pkg::DATA_W-1:0];
				bnm_pkg::CFG_CC_THR:     cfg_q.cc_thr     <= cfg_data[bnm_pkg::DATA_W-1:0];
				bnm_pkg::CFG_CC_NUM:     cfg_q.cc_num     <= cfg_data[bnm_pkg::DATA_W-1:0];
				bnm_pkg::CFG_SETTLE:     cfg_q.settle     <= cfg_data[bnm_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_s1    <= key_note;
			breath_s1 <= breath_level;
			vel_s1    <= velocity;
		end
	end

	bnm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.key    (key_s1),
		.breath (breath_s1),
		.vel    (vel_s1),
		.cfg    (cfg_q),
		.ev0    (ev0),
		.ev1    (ev1),
		.ev_cnt (ev_cnt)
	);

	bnm_evq u_evq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (fire ? ev_cnt : 2'd0),
		.ev0       (ev0),
		.ev1       (ev1),
		.pop       (!out_stall),
		.head      (head),
		.not_empty (out_valid),
		.room      (room)
	);

	assign event_kind   = head.kind;
	assign data_first   = head.first;
	assign data_second  = head.second;
	assign final_of_run = head.last;

	// a stalled stage-1 item is not overwritten
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !room) |=> (valid_s1 && $stable(key_s1) && $stable(breath_s1)))
		else $error("stage 1 item lost while stalled");

endmodule

`default_nettype wire

@@ verif/bnm_event_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnm_event_checker
// Watches the tick and event channels of the breath/note MIDI event
// generator. Every accepted tick is run through a cycle-free copy of the
// note, breath and legato state kept here, and the events it must cause are
// queued. Every accepted event is compared field by field, in order, against
// the oldest queued one.
// ----------------------------------------------------------------------------
module bnm_event_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic [bnm_pkg::NOTE_W-1:0]    key_note,
	input  wire logic [bnm_pkg::DATA_W-1:0]    breath_level,
	input  wire logic [bnm_pkg::DATA_W-1:0]    velocity,

	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic [1:0]                    event_kind,
	input  wire logic [bnm_pkg::DATA_W-1:0]    data_first,
	input  wire logic [bnm_pkg::DATA_W-1:0]    data_second,
	input  wire logic                          final_of_run,

	input  wire logic                          cfg_we,
	input  wire logic [bnm_pkg::CIDX_W-1:0]    cfg_index,
	input  wire logic [bnm_pkg::CFG_W-1:0]     cfg_data,

	output int                                 mismatches,
	output int                                 events_due
);

	logic [bnm_pkg::DATA_W-1:0] breath_thr;
	logic [bnm_pkg::DATA_W-1:0] cc_thr;
	logic [bnm_pkg::DATA_W-1:0] cc_num;
	logic [bnm_pkg::TICK_W-1:0] settle_len;

	logic                       sounding;
	logic [bnm_pkg::NOTE_W-1:0] held;
	logic [bnm_pkg::DATA_W-1:0] last_cc;
	logic                       settling;
	logic [bnm_pkg::NOTE_W-1:0] candidate;
	logic [bnm_pkg::TICK_W-1:0] stable_ticks;
	logic [bnm_pkg::DATA_W-1:0] legato_vel;

	bnm_pkg::event_t            awaited_events[$];
	bnm_pkg::event_t            oldest;

	initial begin
		mismatches = 0;
		events_due = 0;
	end

	task automatic report_mismatch(input string what);
		$display("%0t ns  event mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic derive_midi_events(input logic [bnm_pkg::NOTE_W-1:0] key,
	                                  input logic [bnm_pkg::DATA_W-1:0] breath,
	                                  input logic [bnm_pkg::DATA_W-1:0] vel);
		bnm_pkg::event_t evs [2];
		int              n;
		int              gap;
		n = 0;
		if (settling) begin
			if (key != candidate) begin
				candidate    = key;
				stable_ticks = '0;
			end else begin
				if (stable_ticks != '1)
					stable_ticks = stable_ticks + 1'b1;
				if (stable_ticks >= settle_len) begin
					evs[0]   = '{bnm_pkg::EV_ON, candidate, legato_vel, 1'b0};
					evs[1]   = '{bnm_pkg::EV_OFF, held, legato_vel, 1'b0};
					n        = 2;
					held     = candidate;
					settling = 1'b0;
					sounding = 1'b1;
				end
			end
		end else begin
			gap = (breath > last_cc) ? int'(breath) - int'(last_cc)
			                         : int'(last_cc) - int'(breath);
			if (gap > int'(cc_thr)) begin
				evs[n]  = '{bnm_pkg::EV_CC, cc_num, breath, 1'b0};
				n++;
				last_cc = breath;
			end
			if (breath < breath_thr) begin
				if (sounding) begin
					evs[n]   = '{bnm_pkg::EV_OFF, held, breath, 1'b0};
					n++;
					sounding = 1'b0;
				end
			end else if (key != '0) begin
				if (!sounding) begin
					evs[n]   = '{bnm_pkg::EV_ON, key, vel, 1'b0};
					n++;
					held     = key;
					sounding = 1'b1;
				end else if (key != held) begin
					settling     = 1'b1;
					candidate    = key;
					stable_ticks = '0;
					legato_vel   = vel;
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			evs[i].last = (i == n - 1);
			awaited_events.push_back(evs[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			breath_thr   = bnm_pkg::RST_BREATH_THR;
			cc_thr       = bnm_pkg::RST_CC_THR;
			cc_num       = bnm_pkg::RST_CC_NUM;
			settle_len   = bnm_pkg::RST_SETTLE;
			sounding     = 1'b0;
			held         = '0;
			last_cc      = '0;
			settling     = 1'b0;
			candidate    = '0;
			stable_ticks = '0;
			legato_vel   = '0;
			awaited_events.delete();
			events_due  <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_events.size() == 0) begin
					report_mismatch($sformatf("unexpected kind %0d first %0d second %0d last %0b",
						event_kind, data_first, data_second, final_of_run));
				end else begin
					oldest = awaited_events.pop_front();
					if (event_kind !== oldest.kind)
						report_mismatch($sformatf("kind %0d, want %0d", event_kind, oldest.kind));
					if (data_first !== oldest.first)
						report_mismatch($sformatf("first %0d, want %0d", data_first, oldest.first));
					if (data_second !== oldest.second)
						report_mismatch($sformatf("second %0d, want %0d", data_second,
							oldest.second));
					if (final_of_run !== oldest.last)
						report_mismatch($sformatf("final_of_run %0b, want %0b", final_of_run,
							oldest.last));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					bnm_pkg::CFG_BREATH_THR: breath_thr = cfg_data[bnm_pkg::DATA_W-1:0];
					bnm_pkg::CFG_CC_THR:     cc_thr     = cfg_data[bnm_pkg::DATA_W-1:0];
					bnm_pkg::CFG_CC_NUM:     cc_num     = cfg_data[bnm_pkg::DATA_W-1:0];
					bnm_pkg::CFG_SETTLE:     settle_len = cfg_data[bnm_pkg::TICK_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				derive_midi_events(key_note, breath_level, velocity);
			events_due <= awaited_events.size();
		end
	end

endmodule

@@ verif/breath_note_midi_event_generator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breath_note_midi_event_generator_tb
// Drives the generator with a short directed run through note on/off,
// control change thresholds and legato settling corner cases, then with
// random phrases (held notes, legato changes, key glitches, releases) mixed
// with noise ticks, over several register settings and handshake paces.
// The checker beside the block predicts and compares every event.
// ----------------------------------------------------------------------------
module breath_note_midi_event_generator_tb;

	typedef enum logic [1:0] {
		PACE_SLOW_RX,
		PACE_SLOW_TX,
		PACE_FULL
	} pace_t;

	logic                         clk          = 1'b0;
	logic                         arst_n       = 1'b0;
	logic                         in_valid     = 1'b0;
	logic                         in_stall;
	logic [bnm_pkg::NOTE_W-1:0]   key_note     = '0;
	logic [bnm_pkg::DATA_W-1:0]   breath_level = '0;
	logic [bnm_pkg::DATA_W-1:0]   velocity     = '0;
	logic                         out_valid;
	logic                         out_stall    = 1'b0;
	logic [1:0]                   event_kind;
	logic [bnm_pkg::DATA_W-1:0]   data_first;
	logic [bnm_pkg::DATA_W-1:0]   data_second;
	logic                         final_of_run;
	logic                         cfg_we       = 1'b0;
	logic [bnm_pkg::CIDX_W-1:0]   cfg_index    = '0;
	logic [bnm_pkg::CFG_W-1:0]    cfg_data     = '0;

	int                           mismatches;
	int                           events_due;
	pace_t                        pace         = PACE_SLOW_RX;
	int                           cur_thr      = 10;
	int                           cur_settle   = 25;

	breath_note_midi_event_generator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.key_note     (key_note),
		.breath_level (breath_level),
		.velocity     (velocity),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.data_first   (data_first),
		.data_second  (data_second),
		.final_of_run (final_of_run),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	bnm_event_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.key_note     (key_note),
		.breath_level (breath_level),
		.velocity     (velocity),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.data_first   (data_first),
		.data_second  (data_second),
		.final_of_run (final_of_run),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.events_due   (events_due)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		case (pace)
			PACE_SLOW_RX: out_stall <= ($urandom_range(0, 99) < 49);
			PACE_SLOW_TX: out_stall <= ($urandom_range(0, 99) < 26);
			default:      out_stall <= 1'b0;
		endcase
	end

	function automatic bit sender_waits();
		case (pace)
			PACE_SLOW_RX: return $urandom_range(0, 99) < 26;
			PACE_SLOW_TX: return $urandom_range(0, 99) < 49;
			default:      return 1'b0;
		endcase
	endfunction

	task automatic send_item(input int k, input int b, input int v);
		@(negedge clk);
		while (sender_waits()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		key_note     <= bnm_pkg::NOTE_W'(k);
		breath_level <= bnm_pkg::DATA_W'(b);
		velocity     <= bnm_pkg::DATA_W'(v);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [bnm_pkg::CIDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= bnm_pkg::CFG_W'(val);
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// a tick may cause no event while the block is still busy; allow for it
	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (events_due != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic play_phrases(input int count);
		int sent;
		int notes;
		int hold;
		int cap;
		int key;
		sent = 0;
		cap  = (cur_settle > 8) ? 8 : cur_settle;
		while (sent < count) begin
			if ($urandom_range(0, 4) == 0) begin
				send_item(int'($urandom_range(0, 127)), int'($urandom_range(0, 127)),
					int'($urandom_range(0, 127)));
				sent++;
			end else begin
				notes = $urandom_range(1, 5);
				for (int n = 0; n < notes; n++) begin
					key  = ($urandom_range(0, 15) == 0) ? 0 : int'($urandom_range(1, 127));
					hold = $urandom_range(1, cap + 3);
					for (int h = 0; h < hold; h++) begin
						send_item(($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 127)) : key,
							int'($urandom_range(cur_thr, 127)), int'($urandom_range(0, 127)));
						sent++;
					end
				end
				if (cur_thr > 0) begin
					repeat ($urandom_range(1, 3)) begin
						send_item(int'($urandom_range(0, 127)),
							int'($urandom_range(0, cur_thr - 1)), int'($urandom_range(0, 127)));
						sent++;
					end
				end
			end
		end
	endtask

	task automatic run_phase(input int thr, input int cc, input int num, input int settle,
	                         input int count, input pace_t p);
		wait_drain();
		write_reg(bnm_pkg::CFG_BREATH_THR, thr);
		write_reg(bnm_pkg::CFG_CC_THR, cc);
		write_reg(bnm_pkg::CFG_CC_NUM, num);
		write_reg(bnm_pkg::CFG_SETTLE, settle);
		cur_thr    = thr;
		cur_settle = settle;
		pace       = p;
		play_phrases(count);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero settle time, threshold edges, zero and repeated legato targets
		run_phase(10, 1, 127, 0, 0, PACE_SLOW_RX);
		send_item(0, 0, 0);
		send_item(127, 127, 127);
		send_item(127, 127, 0);
		send_item(64, 100, 33);
		send_item(64, 100, 0);
		send_item(70, 100, 5);
		send_item(0, 20, 9);
		send_item(0, 20, 9);
		send_item(50, 90, 7);
		send_item(0, 90, 7);
		send_item(0, 90, 7);
		send_item(0, 3, 1);
		send_item(1, 9, 1);
		send_item(1, 10, 1);
		send_item(1, 11, 0);
		send_item(1, 0, 0);
		send_item(0, 127, 64);
		send_item(99, 126, 127);
		send_item(98, 126, 2);
		send_item(97, 0, 0);
		send_item(97, 0, 0);

		run_phase(0, 0, 0, 1, 300, PACE_SLOW_RX);
		run_phase($urandom_range(1, 126), $urandom_range(0, 6), $urandom_range(0, 127),
			$urandom_range(0, 6), 350, PACE_SLOW_RX);
		run_phase(127, 127, 127, 3, 250, PACE_SLOW_TX);
		run_phase($urandom_range(5, 60), $urandom_range(0, 10), $urandom_range(0, 127),
			65535, 80, PACE_SLOW_TX);
		run_phase($urandom_range(1, 40), $urandom_range(0, 4), $urandom_range(0, 127),
			2, 350, PACE_SLOW_TX);
		run_phase($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
			$urandom_range(0, 5), 300, PACE_FULL);
		run_phase($urandom_range(1, 30), $urandom_range(0, 3), $urandom_range(0, 127),
			$urandom_range(0, 4), 300, PACE_FULL);

		wait_drain();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
